[hdl/assert_macros.svh]
// Assertion macros shared by the fraction reducer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/frd_pkg.sv]
package frd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // One fraction in
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_in;
    logic signed [DATA_WIDTH-1:0] denominator_in;
  } frd_in_t;

  // One reduced fraction out
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator_out;
    logic signed [DATA_WIDTH-1:0] denominator_out;
    logic        [DATA_WIDTH-2:0] common_divisor;
  } frd_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic emit;
  } frd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero;
    logic equal;
    logic div_last;
  } frd_status_t;

endpackage

[hdl/fraction_reduce.sv]
// Reduces one signed fraction to lowest terms and reports the common divisor.
// A transfer in happens on a clock edge with start high and busy low; the
// result then appears for exactly one cycle with done high and must be taken
// then, since the block cannot hold it. The work is a load step, the binary
// gcd loop (one halving or subtract per cycle, operand dependent), restoring
// division of both parts by the shared divisor over DATA_WIDTH quotient bits,
// and an output step. A zero numerator or denominator skips both loops.
// busy drops in the cycle done is shown, so the next fraction may start then.
module fraction_reduce
  import frd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  frd_in_t  operands,
  output logic     busy,
  output logic     done,
  output frd_out_t result
);

  frd_cmd_t    cmd;
  frd_status_t status;

  // Sequencer
  frd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Gcd and division datapath
  frd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

[hdl/frd_ctrl.sv]
`include "assert_macros.svh"

module frd_ctrl
  import frd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  frd_status_t status,
  output frd_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } frd_state_t;

  frd_state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        priority if (status.zero) begin
          state_next = S_OUT;
        end else if (status.equal) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.emit;
    end
  end

  assign busy = (state != S_IDLE);

  // Checks
  `ASSERT_NEXT(a_out_strobes, state == S_OUT, done && state == S_IDLE)
  `ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
  `ASSERT_IMPLY(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule

[hdl/frd_datapath.sv]
`include "assert_macros.svh"

module frd_datapath
  import frd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frd_in_t     operands,
  input  frd_cmd_t    cmd,
  output frd_status_t status,
  output frd_out_t    result
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0]     n_raw, d_raw, n_mag, d_mag;
  logic             n_sign, d_sign;
  logic [W-1:0]     a, b, g;
  logic [CNT_W-1:0] k, cnt;
  logic [W-1:0]     qn, qd, rn, rd;
  logic             nneg, dneg, zero;
  logic [W:0]       rn_sh, rd_sh;
  logic             n_fit, d_fit;
  logic [W-1:0]     diff_ab, diff_ba;

  // Magnitudes of the incoming parts
  assign n_raw  = operands.numerator_in;
  assign d_raw  = operands.denominator_in;
  assign n_sign = n_raw[W-1];
  assign d_sign = d_raw[W-1];
  assign n_mag  = n_sign ? (~n_raw + 1'b1) : n_raw;
  assign d_mag  = d_sign ? (~d_raw + 1'b1) : d_raw;

  // Binary gcd subtractors
  assign diff_ab = a - b;
  assign diff_ba = b - a;

  // One restoring-division bit for each part, shared divisor
  assign rn_sh = {rn, qn[W-1]};
  assign rd_sh = {rd, qd[W-1]};
  assign n_fit = (rn_sh >= {1'b0, g});
  assign d_fit = (rd_sh >= {1'b0, g});

  assign status.zero     = zero;
  assign status.equal    = (a == b);
  assign status.div_last = (cnt == CNT_W'(W - 1));

  always_ff @(posedge clk) begin
    // Capture the operands; quotients start as the magnitudes
    if (cmd.load) begin
      a    <= n_mag;
      b    <= d_mag;
      k    <= '0;
      qn   <= n_mag;
      qd   <= d_mag;
      nneg <= n_sign;
      dneg <= d_sign;
      zero <= (n_mag == '0) || (d_mag == '0);
      g    <= W'(1);
    end

    // Stein step: strip common twos, then halve or subtract
    if (cmd.gcd_step) begin
      priority if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a > b) begin
        a <= diff_ab >> 1;
      end else begin
        b <= diff_ba >> 1;
      end
    end

    // Restore the common twos and clear the remainders
    if (cmd.div_init) begin
      g   <= a << k;
      rn  <= '0;
      rd  <= '0;
      cnt <= '0;
    end

    // One quotient bit per cycle for both parts
    if (cmd.div_step) begin
      rn  <= n_fit ? W'(rn_sh - {1'b0, g}) : rn_sh[W-1:0];
      rd  <= d_fit ? W'(rd_sh - {1'b0, g}) : rd_sh[W-1:0];
      qn  <= {qn[W-2:0], n_fit};
      qd  <= {qd[W-2:0], d_fit};
      cnt <= cnt + 1'b1;
    end

    // Put the signs back
    if (cmd.emit) begin
      result.numerator_out   <= nneg ? (~qn + 1'b1) : qn;
      result.denominator_out <= dneg ? (~qd + 1'b1) : qd;
      result.common_divisor  <= g[W-2:0];
    end
  end

  // Checks
  `ASSERT_IMPLY(a_gcd_nonzero, cmd.gcd_step, a != '0 && b != '0)
  `ASSERT_IMPLY(a_rem_below, cmd.div_step, rn < g && rd < g)
  `ASSERT_NEXT(a_div_start, cmd.div_init, g != '0 && cnt == '0)

endmodule
